### hw/rtl/assert_macros.svh
// Assertion macros shared by the interval set engine RTL.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge out of reset.
`define CISE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check on every edge, reset included.
`define CISE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/cise_pkg.sv
// Shared types and constants of the interval set engine.
// No dependencies; every other .sv file in the RTL imports it.
`default_nettype none

package cise_pkg;

   localparam int MODE_W   = 2;
   localparam int CODE_W   = 21;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [CODE_W-1:0] lo;
      logic [CODE_W-1:0] hi;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic rd_scan;
      logic rd_entry;
      logic proc;
      logic split_wr;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic needs_scan;
      logic needs_read;
      logic rd_more;
      logic need_split;
   } sts_type;

endpackage

`default_nettype wire

### hw/rtl/cise_if.sv
// Valid/ready channel interfaces for the interval set engine.
// Depends on cise_pkg for field widths.
`default_nettype none

interface cise_req_if import cise_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [CODE_W-1:0]   range_start;
   logic [CODE_W-1:0]   range_end;

   modport source (output valid, output mode, output range_start, output range_end,
                   input ready);
   modport sink   (input valid, input mode, input range_start, input range_end,
                   output ready);
endinterface

interface cise_rsp_if import cise_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;
   logic [CODE_W-1:0]   entry_low;
   logic [CODE_W-1:0]   entry_high;

   modport source (output valid, output status, output entry_count, output entry_low,
                   output entry_high, input ready);
   modport sink   (input valid, input status, input entry_count, input entry_low,
                   input entry_high, output ready);
endinterface

`default_nettype wire

### hw/rtl/char_interval_set_engine.sv
// Sorted code-point interval set: insert merges, remove cuts and splits, read
// returns entry k, clear empties the set. One transaction is in flight at a
// time. Insert and remove walk every stored entry through the single read
// port of the entry memory, one entry a cycle except while a second piece
// of a split is written, and write the new list into a shadow bank that is
// swapped in on success, so a refused operation leaves the set as it was.
// A finished result waits in the output register while the next transaction
// is accepted. The memory holds 2 * MAX_INTERVALS entries and needs no
// clearing after reset.
// Depends on cise_pkg, cise_if, cise_ctrl, cise_datapath, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module char_interval_set_engine import cise_pkg::*; #(
   parameter int MAX_INTERVALS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   cise_req_if.sink   req_chan,
   cise_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   cise_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cise_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_chan.mode),
      .req_range_start (req_chan.range_start),
      .req_range_end   (req_chan.range_end),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_entry_low   (rsp_chan.entry_low),
      .rsp_entry_high  (rsp_chan.entry_high)
   );

   `CISE_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_chan.ready, "not ready after reset")
   `CISE_ASSERT(a_busy_after_accept, req_chan.valid && req_chan.ready |=> !req_chan.ready,
                "accepted a second transaction while busy")
   `CISE_ASSERT(a_split_follows, cmd.proc && sts.need_split |=> cmd.split_wr,
                "second piece of a split not written")
   `CISE_ASSERT(a_range_zero, rsp_chan.valid && rsp_chan.status == STATUS_RANGE |->
                rsp_chan.entry_low == '0 && rsp_chan.entry_high == '0,
                "out-of-range read returned data")

endmodule

`default_nettype wire

### hw/rtl/cise_datapath.sv
// Datapath of the interval set engine: double-buffered entry memory,
// per-entry merge/cut logic, entry count and response registers. Uses cise_pkg.
`default_nettype none

module cise_datapath import cise_pkg::*; #(
   parameter int MAX_INTERVALS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [CODE_W-1:0]   req_range_start,
   input  wire logic [CODE_W-1:0]   req_range_end,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic [CODE_W-1:0]        rsp_entry_low,
   output logic [CODE_W-1:0]        rsp_entry_high
);

   localparam int IW    = $clog2(MAX_INTERVALS);
   localparam int CW    = $clog2(MAX_INTERVALS + 1);
   localparam int NW    = $clog2(MAX_INTERVALS + 2);
   localparam int AW    = $clog2(2 * MAX_INTERVALS);
   localparam int DEPTH = 2 * MAX_INTERVALS;
   localparam logic [AW-1:0] BANK_OFS = AW'(MAX_INTERVALS);
   localparam logic [NW-1:0] N_MAX    = NW'(MAX_INTERVALS);

   entry_type           mem_ff [DEPTH];
   entry_type           rd_data_ff;
   mode_type            mode_ff;
   logic [CODE_W-1:0]   s_ff, e_ff, ns_ff, ne_ff;
   logic [CODE_W-1:0]   ns_in, ne_in;
   logic                placed_ff, placed_in;
   logic [NW-1:0]       n_ff;
   logic [CW-1:0]       rd_idx_ff;
   entry_type           pend_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                bank_ff, bank_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [CODE_W-1:0]   rsp_low_ff, rsp_high_ff;

   logic [CODE_W-1:0]   a, b;
   logic [CODE_W:0]     b_p1, ne_p1;
   logic [1:0]          piece_cnt;
   entry_type           p0, p1, lo_piece, hi_piece;
   logic                has_lo, has_hi;

   logic                wr_en;
   entry_type           wr_entry;
   logic [IW-1:0]       wr_idx, rd_idx;
   logic [AW-1:0]       wr_addr, rd_addr;

   logic                final_place;
   logic [NW-1:0]       n_final;
   status_type          status_in;
   logic [CODE_W-1:0]   low_in, high_in;
   logic [CW+COUNT_W-1:0] cnt_ext;

   // Status toward the controller
   assign sts.needs_scan = (mode_ff == MODE_INSERT || mode_ff == MODE_REMOVE) &&
                           (e_ff >= s_ff);
   assign sts.needs_read = (mode_ff == MODE_READ) && (s_ff < CODE_W'(cnt_ff));
   assign sts.rd_more    = rd_idx_ff < cnt_ff;
   assign sts.need_split = piece_cnt == 2'd2;

   // Per-entry merge (insert) and cut (remove)
   assign a     = rd_data_ff.lo;
   assign b     = rd_data_ff.hi;
   assign b_p1  = {1'b0, b} + 1'b1;
   assign ne_p1 = {1'b0, ne_ff} + 1'b1;

   always_comb begin
      lo_piece  = '{lo: a, hi: s_ff - 1'b1};
      hi_piece  = '{lo: e_ff + 1'b1, hi: b};
      has_lo    = a < s_ff;
      has_hi    = b > e_ff;
      piece_cnt = 2'd0;
      p0        = rd_data_ff;
      p1        = rd_data_ff;
      ns_in     = ns_ff;
      ne_in     = ne_ff;
      placed_in = placed_ff;
      if (mode_ff == MODE_INSERT) begin
         if (b_p1 < {1'b0, ns_ff}) begin
            piece_cnt = 2'd1;
         end else if ({1'b0, a} > ne_p1) begin
            if (!placed_ff) begin
               // Drop the merged interval in ahead of this entry
               piece_cnt = 2'd2;
               p0        = '{lo: ns_ff, hi: ne_ff};
               placed_in = 1'b1;
            end else begin
               piece_cnt = 2'd1;
            end
         end else begin
            ns_in = (a < ns_ff) ? a : ns_ff;
            ne_in = (b > ne_ff) ? b : ne_ff;
         end
      end else begin
         if (b < s_ff || a > e_ff) begin
            piece_cnt = 2'd1;
         end else if (has_lo && has_hi) begin
            piece_cnt = 2'd2;
            p0        = lo_piece;
            p1        = hi_piece;
         end else if (has_lo) begin
            piece_cnt = 2'd1;
            p0        = lo_piece;
         end else if (has_hi) begin
            piece_cnt = 2'd1;
            p0        = hi_piece;
         end
      end
   end

   // Write port: scanned piece, held second piece, or final placement
   assign final_place = (mode_ff == MODE_INSERT) && !placed_ff;
   assign n_final     = n_ff + NW'(final_place);
   assign wr_idx      = n_ff[IW-1:0];

   always_comb begin
      wr_en    = 1'b0;
      wr_entry = p0;
      if (cmd.proc && piece_cnt != 2'd0) begin
         wr_en = 1'b1;
      end else if (cmd.split_wr) begin
         wr_en    = 1'b1;
         wr_entry = pend_ff;
      end else if (cmd.finish && sts.needs_scan && final_place) begin
         wr_en    = 1'b1;
         wr_entry = '{lo: ns_ff, hi: ne_ff};
      end
      // Pieces past capacity only count toward the overflow check
      if (n_ff >= N_MAX) begin
         wr_en = 1'b0;
      end
   end

   // Writes go to the shadow bank, reads come from the live bank
   assign wr_addr = bank_ff ? AW'(wr_idx) : BANK_OFS + AW'(wr_idx);
   assign rd_idx  = cmd.rd_entry ? s_ff[IW-1:0] : rd_idx_ff[IW-1:0];
   assign rd_addr = bank_ff ? BANK_OFS + AW'(rd_idx) : AW'(rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (cmd.rd_scan || cmd.rd_entry) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Completion: commit or refuse, build the response
   always_comb begin
      cnt_in    = cnt_ff;
      bank_in   = bank_ff;
      status_in = STATUS_OK;
      low_in    = '0;
      high_in   = '0;
      unique case (mode_ff)
         MODE_INSERT, MODE_REMOVE: begin
            if (sts.needs_scan) begin
               if (n_final > N_MAX) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  cnt_in  = CW'(n_final);
                  bank_in = !bank_ff;
               end
            end
         end
         MODE_READ: begin
            if (sts.needs_read) begin
               low_in  = rd_data_ff.lo;
               high_in = rd_data_ff.hi;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         MODE_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   assign cnt_ext = {{COUNT_W{1'b0}}, cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         bank_ff   <= 1'b0;
         n_ff      <= '0;
         rd_idx_ff <= '0;
         placed_ff <= 1'b0;
      end else if (cmd.load) begin
         n_ff      <= '0;
         rd_idx_ff <= '0;
         placed_ff <= 1'b0;
      end else begin
         if (cmd.rd_scan) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmd.proc) begin
            placed_ff <= placed_in;
            n_ff      <= n_ff + NW'(piece_cnt != 2'd0);
         end
         if (cmd.split_wr) begin
            n_ff <= n_ff + 1'b1;
         end
         if (cmd.finish) begin
            cnt_ff  <= cnt_in;
            bank_ff <= bank_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         s_ff    <= req_range_start;
         e_ff    <= req_range_end;
         ns_ff   <= req_range_start;
         ne_ff   <= req_range_end;
      end
      if (cmd.proc) begin
         ns_ff   <= ns_in;
         ne_ff   <= ne_in;
         pend_ff <= p1;
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= cnt_ext[COUNT_W-1:0];
         rsp_low_ff    <= low_in;
         rsp_high_ff   <= high_in;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_entry_low   = rsp_low_ff;
   assign rsp_entry_high  = rsp_high_ff;

endmodule

`default_nettype wire

### hw/rtl/cise_ctrl.sv
// Controller of the interval set engine: sequences accept, scan, split
// writes and completion, and owns the response valid. Uses cise_pkg.
`default_nettype none

module cise_ctrl import cise_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SPLIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      proc_vld_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_ready = state_ff == ST_IDLE;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd.load     = req_valid && req_ready;
   assign cmd.rd_entry = (state_ff == ST_DISPATCH) && sts.needs_read;
   assign cmd.rd_scan  = (state_ff == ST_SCAN) && sts.rd_more;
   assign cmd.proc     = (state_ff == ST_SCAN) && proc_vld_ff;
   assign cmd.split_wr = state_ff == ST_SPLIT;
   assign cmd.finish   = (state_ff == ST_FINISH) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               proc_vld_ff <= 1'b0;
               state_ff    <= sts.needs_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
               // Read data is registered and lands in the cycle after its address
               proc_vld_ff <= cmd.rd_scan;
               if (cmd.proc && sts.need_split) begin
                  state_ff <= ST_SPLIT;
               end else if (!cmd.rd_scan && !proc_vld_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SPLIT: begin
               // Hold the pending read; it is processed on return
               state_ff <= ST_SCAN;
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for char_interval_set_engine: insert, remove, read and clear
// transactions are predicted against a local copy of the interval set.
// Depends on cise_pkg, cise_if and the engine RTL.
`timescale 1ns / 1ps

module tb import cise_pkg::*; ();

   localparam int          SET_CAP     = 32;
   localparam int unsigned CODE_MAX    = 'h1FFFFF;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          TAIL_CYCLES = 50;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic [CODE_W-1:0]  low;
      logic [CODE_W-1:0]  high;
   } set_reply_type;

   logic clock;
   logic reset;

   cise_req_if req_chan ();
   cise_rsp_if rsp_chan ();

   char_interval_set_engine #(.MAX_INTERVALS(SET_CAP)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Local copy of the set
   logic [CODE_W-1:0] set_lo [SET_CAP];
   logic [CODE_W-1:0] set_hi [SET_CAP];
   int unsigned       set_size;

   // New list built by one insert or remove
   int unsigned       fresh_lo [$];
   int unsigned       fresh_hi [$];

   set_reply_type set_replies [$];

   int  error_count;
   int  results_checked;
   int  op_total [4];
   int  refused_total;
   int  out_of_range_total;
   int  largest_set;
   int  cycle_count;
   bit  req_steady;
   bit  rsp_steady;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                  set_replies.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_piece(int unsigned lo, int unsigned hi);
      fresh_lo = {fresh_lo, lo};
      fresh_hi = {fresh_hi, hi};
   endfunction

   // Apply one transaction to the local set and return the result it gives
   function automatic set_reply_type run_set_op(mode_type m, logic [CODE_W-1:0] s_in,
                                                logic [CODE_W-1:0] e_in);
      set_reply_type reply;
      int unsigned   s, e, ns, ne, a, b;
      bit            placed;
      reply.status = STATUS_OK;
      reply.low    = '0;
      reply.high   = '0;
      s = 32'(s_in);
      e = 32'(e_in);
      placed = 0;
      fresh_lo.delete();
      fresh_hi.delete();
      case (m)
         MODE_INSERT: begin
            if (e >= s) begin
               ns = s;
               ne = e;
               for (int i = 0; i < set_size; i++) begin
                  a = 32'(set_lo[i]);
                  b = 32'(set_hi[i]);
                  if (b + 1 < ns) begin
                     add_piece(a, b);
                  end else if (a > ne + 1) begin
                     if (!placed) begin
                        add_piece(ns, ne);
                        placed = 1;
                     end
                     add_piece(a, b);
                  end else begin
                     // overlapping or touching: absorb
                     if (a < ns) ns = a;
                     if (b > ne) ne = b;
                  end
               end
               if (!placed) begin
                  add_piece(ns, ne);
               end
            end
         end
         MODE_REMOVE: begin
            if (e >= s) begin
               for (int i = 0; i < set_size; i++) begin
                  a = 32'(set_lo[i]);
                  b = 32'(set_hi[i]);
                  if (b < s || a > e) begin
                     add_piece(a, b);
                  end else begin
                     if (a < s) begin
                        add_piece(a, s - 1);
                     end
                     if (b > e) begin
                        add_piece(e + 1, b);
                     end
                  end
               end
            end
         end
         MODE_READ: begin
            if (s < set_size) begin
               reply.low  = set_lo[s];
               reply.high = set_hi[s];
            end else begin
               reply.status = STATUS_RANGE;
               out_of_range_total++;
            end
         end
         MODE_CLEAR: set_size = 0;
         default: ;
      endcase
      if ((m == MODE_INSERT || m == MODE_REMOVE) && e >= s) begin
         if (fresh_lo.size() > SET_CAP) begin
            // refused: the set stays as it was
            reply.status = STATUS_OVERFLOW;
            refused_total++;
         end else begin
            for (int i = 0; i < fresh_lo.size(); i++) begin
               set_lo[i] = fresh_lo[i][CODE_W-1:0];
               set_hi[i] = fresh_hi[i][CODE_W-1:0];
            end
            set_size = fresh_lo.size();
         end
      end
      if (int'(set_size) > largest_set) largest_set = int'(set_size);
      reply.count = set_size[COUNT_W-1:0];
      return reply;
   endfunction

   task automatic send_op(input mode_type m, input int unsigned s, input int unsigned e);
      int gap;
      gap = req_steady ? 0 : idle_len();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      req_chan.mode        = m;
      req_chan.range_start = s[CODE_W-1:0];
      req_chan.range_end   = e[CODE_W-1:0];
      req_chan.valid       = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      set_replies = {set_replies, run_set_op(m, s[CODE_W-1:0], e[CODE_W-1:0])};
      op_total[int'(m)]++;
   endtask

   // Hold the request side until every owed result has come back
   task automatic drain_replies();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (set_replies.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                  $time, name, want, want, got, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      set_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (set_replies.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d count %0d %0h..%0h",
                     $time, rsp_chan.status, rsp_chan.entry_count, rsp_chan.entry_low,
                     rsp_chan.entry_high);
            error_count++;
         end else begin
            want = set_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_chan.status));
            check_field("entry_count", 32'(want.count), 32'(rsp_chan.entry_count));
            check_field("entry_low", 32'(want.low), 32'(rsp_chan.entry_low));
            check_field("entry_high", 32'(want.high), 32'(rsp_chan.entry_high));
         end
         results_checked++;
      end
   end

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!rsp_steady && $urandom_range(0, 2) == 0) begin
            stall = idle_len();
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   task automatic test_directed();
      send_op(MODE_READ, 0, 0);
      send_op(MODE_READ, CODE_MAX, CODE_MAX);
      // empty intervals change nothing
      send_op(MODE_INSERT, 5, 4);
      send_op(MODE_REMOVE, CODE_MAX, 0);
      send_op(MODE_INSERT, 0, 0);
      send_op(MODE_INSERT, CODE_MAX, CODE_MAX);
      send_op(MODE_INSERT, 2, 3);
      send_op(MODE_INSERT, 1, 1);
      send_op(MODE_INSERT, 4, 4);
      send_op(MODE_READ, 0, 0);
      send_op(MODE_READ, 2, 0);
      send_op(MODE_REMOVE, 0, 0);
      send_op(MODE_REMOVE, 2, 2);
      send_op(MODE_REMOVE, CODE_MAX, CODE_MAX);
      send_op(MODE_INSERT, 'h100000, CODE_MAX);
      send_op(MODE_REMOVE, CODE_MAX - 1, CODE_MAX);
      send_op(MODE_READ, 2, 0);
      send_op(MODE_REMOVE, 0, CODE_MAX);
      send_op(MODE_INSERT, 0, CODE_MAX);
      send_op(MODE_REMOVE, 'h0AAAAA, 'h155555);
      send_op(MODE_READ, 0, 0);
      send_op(MODE_READ, 1, 0);
      send_op(MODE_CLEAR, 0, 0);
      send_op(MODE_READ, 0, 0);
   endtask

   // Fill the set to capacity, then hit refusals and merges at the limit
   task automatic test_capacity(input int unsigned base);
      int unsigned slot [SET_CAP];
      int unsigned k, j, t, lo;
      send_op(MODE_CLEAR, 0, 0);
      for (int i = 0; i < SET_CAP; i++) slot[i] = i;
      for (int i = SET_CAP - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = slot[i];
         slot[i] = slot[j];
         slot[j] = t;
      end
      for (int i = 0; i < SET_CAP; i++) begin
         lo = base + 8 * slot[i];
         send_op(MODE_INSERT, lo, lo + $urandom_range(2, 4));
      end
      send_op(MODE_READ, SET_CAP - 1, 0);
      send_op(MODE_READ, SET_CAP, 0);
      k  = $urandom_range(0, SET_CAP - 2);
      lo = base + 8 * k;
      send_op(MODE_INSERT, lo + 6, lo + 6);
      send_op(MODE_INSERT, base + 8 * SET_CAP + 6, base + 8 * SET_CAP + 7);
      send_op(MODE_REMOVE, lo + 1, lo + 1);
      send_op(MODE_INSERT, lo + 5, lo + 5);
      send_op(MODE_INSERT, lo, lo + 9);
      send_op(MODE_REMOVE, lo + 1, lo + 1);
      send_op(MODE_REMOVE, lo + 3, lo + 3);
      send_op(MODE_READ, SET_CAP - 1, 0);
      send_op(MODE_REMOVE, base + 3, base + 8 * SET_CAP);
      send_op(MODE_READ, 0, 0);
   endtask

   task automatic test_random(input int total);
      int unsigned base, span, s, e, a, b, k, r;
      mode_type    op;
      for (int i = 0; i < total; i++) begin
         if (i % 100 == 0) begin
            // new phase: other idle pattern and code window
            req_steady = (i / 100) % 4 == 1;
            rsp_steady = (i / 100) % 4 == 2;
            r = $urandom_range(0, 3);
            span = (r == 0) ? 64 : (r == 1) ? 512 : (r == 2) ? 8192 : CODE_MAX;
            base = (span == CODE_MAX) ? 0 : $urandom_range(0, CODE_MAX - span);
            if (span != CODE_MAX && $urandom_range(0, 3) == 0)
               base = $urandom_range(0, 1) ? 0 : CODE_MAX - span;
         end
         if (i % 250 == 249) drain_replies();
         r = $urandom_range(0, 99);
         if (r < 45) op = MODE_INSERT;
         else if (r < 70) op = MODE_REMOVE;
         else if (r < 98) op = MODE_READ;
         else op = MODE_CLEAR;
         s = base + $urandom_range(0, span);
         r = $urandom_range(0, 9);
         if (r == 0) e = s - $urandom_range(1, 8);
         else if (r < 8) e = s + $urandom_range(0, span / 16 + 1);
         else e = s + $urandom_range(0, span);
         if (set_size > 0) begin
            k = $urandom_range(0, set_size - 1);
            a = 32'(set_lo[k]);
            b = 32'(set_hi[k]);
            // aim a cut inside an entry, or an insert just past one
            if (op == MODE_REMOVE && $urandom_range(0, 2) == 0) begin
               s = a + $urandom_range(0, b - a);
               e = s + $urandom_range(0, b - s);
            end else if (op == MODE_INSERT && $urandom_range(0, 4) == 0) begin
               s = b + $urandom_range(1, 2);
               e = s + $urandom_range(0, 4);
            end
         end
         if (op == MODE_READ)
            s = ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, set_size + 1);
         send_op(op, s, e);
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_INSERT;
      req_chan.range_start = '0;
      req_chan.range_end   = '0;
      req_steady           = 1'b0;
      rsp_steady           = 1'b0;
      set_size             = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      drain_replies();
      test_capacity(0);
      test_capacity($urandom_range(1, CODE_MAX - 8 * SET_CAP - 16));
      test_capacity(CODE_MAX - 8 * SET_CAP - 7);
      drain_replies();
      test_random(1500);
      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d transactions (ins %0d, rem %0d, rd %0d, clr %0d), %0d checked",
               op_total.sum(), op_total[MODE_INSERT], op_total[MODE_REMOVE],
               op_total[MODE_READ], op_total[MODE_CLEAR], results_checked);
      $display("Capacity refusals %0d, out-of-range reads %0d, largest set %0d entries",
               refused_total, out_of_range_total, largest_set);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cise_pkg.sv
hw/rtl/cise_if.sv
hw/rtl/cise_datapath.sv
hw/rtl/cise_ctrl.sv
hw/rtl/char_interval_set_engine.sv
tb/tb.sv
